[rtl/mfmd_pkg.sv]
// ----------------------------------------------------------------------------
// mfmd_pkg
// Shared types and constants for the market feed message decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mfmd_pkg;

    // message type bytes
    localparam logic [7:0] TYPE_ADD      = 8'h41;  // 'A'
    localparam logic [7:0] TYPE_ADD_MPID = 8'h46;  // 'F'
    localparam logic [7:0] TYPE_EXEC     = 8'h45;  // 'E'
    localparam logic [7:0] TYPE_EXEC_PX  = 8'h43;  // 'C'
    localparam logic [7:0] TYPE_CANCEL   = 8'h58;  // 'X'
    localparam logic [7:0] TYPE_DELETE   = 8'h44;  // 'D'
    localparam logic [7:0] TYPE_REPLACE  = 8'h55;  // 'U'
    localparam logic [7:0] TYPE_TRADE    = 8'h50;  // 'P'
    localparam logic [7:0] TYPE_DIR      = 8'h52;  // 'R'

    localparam logic [7:0] SIDE_BUY = 8'h42;       // 'B'

    // event kinds
    localparam logic [3:0] KIND_ADD     = 4'd0;
    localparam logic [3:0] KIND_EXEC    = 4'd1;
    localparam logic [3:0] KIND_CANCEL  = 4'd2;
    localparam logic [3:0] KIND_DELETE  = 4'd3;
    localparam logic [3:0] KIND_REPLACE = 4'd4;
    localparam logic [3:0] KIND_TRADE   = 4'd5;
    localparam logic [3:0] KIND_DIR     = 4'd6;
    localparam logic [3:0] KIND_IGNORED = 4'd7;
    localparam logic [3:0] KIND_ERROR   = 4'd8;

    // minimum message lengths per type
    localparam logic [15:0] MIN_LEN_TYPED   = 16'd3;
    localparam logic [15:0] MIN_LEN_ADD     = 16'd36;
    localparam logic [15:0] MIN_LEN_EXEC    = 16'd32;
    localparam logic [15:0] MIN_LEN_CANCEL  = 16'd20;
    localparam logic [15:0] MIN_LEN_DELETE  = 16'd12;
    localparam logic [15:0] MIN_LEN_REPLACE = 16'd36;
    localparam logic [15:0] MIN_LEN_TRADE   = 16'd44;
    localparam logic [15:0] MIN_LEN_DIR     = 16'd40;
    localparam logic [15:0] MIN_LEN_ANY     = 16'd2;

    localparam logic [38:0] PRICE_SCALE = 39'd100;

    // capture stage to event build
    typedef struct packed {
        logic        emit;        // last byte of a message accepted this cycle
        logic [15:0] msg_size;    // effective length, current byte included
        logic [7:0]  msg_type;    // effective type, current byte included
        logic [63:0] first_ref;
        logic [63:0] second_ref;
        logic [31:0] shares;
        logic [38:0] scaled_price;
        logic [31:0] mpid;
        logic [7:0]  side;
        logic [7:0]  locate;
    } cap_t;

    // one decoded event
    typedef struct packed {
        logic [3:0]  event_kind;
        logic [63:0] order_ref;
        logic [63:0] new_order_ref;
        logic [31:0] share_count;
        logic [38:0] scaled_price;
        logic        is_sell;
        logic [8:0]  symbol_number;
        logic [63:0] match_ref;
        logic [31:0] mpid_word;
        logic        mpid_present;
    } res_t;

    function automatic logic in_span(input logic [15:0] p, input logic [15:0] lo,
                                     input logic [15:0] hi);
        return (p >= lo) && (p <= hi);
    endfunction

endpackage

`default_nettype wire

[rtl/mfmd_field_capture.sv]
// ----------------------------------------------------------------------------
// mfmd_field_capture
// Tracks byte position in the length-prefixed stream and shifts in fields.
// ----------------------------------------------------------------------------
`default_nettype none

module mfmd_field_capture (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           beat,
    input  wire logic [7:0]     data,
    output mfmd_pkg::cap_t      cap
);

    logic [15:0] pos_reg,    pos_next;
    logic [15:0] size_reg,   size_next;
    logic [7:0]  type_reg,   type_next;
    logic [63:0] ref1_reg,   ref1_next;
    logic [63:0] ref2_reg,   ref2_next;
    logic [31:0] shares_reg, shares_next;
    logic [31:0] price_reg,  price_next;
    logic [31:0] mpid_reg,   mpid_next;
    logic [7:0]  side_reg,   side_next;
    logic [7:0]  locate_reg, locate_next;
    logic [38:0] scaled_reg;

    logic [15:0] size_eff;
    logic [15:0] size_raw;
    logic [7:0]  type_eff;
    logic        addlike, exec, hasref, last;

    always_comb begin
        size_raw = {size_reg[15:8], data};
        if (pos_reg == 16'd1) begin
            size_eff = (size_raw < mfmd_pkg::MIN_LEN_ANY) ? mfmd_pkg::MIN_LEN_ANY : size_raw;
        end else begin
            size_eff = size_reg;
        end
        type_eff = (pos_reg == 16'd2) ? data : type_reg;
        last = (pos_reg != 16'd0) && (({1'b0, pos_reg} + 17'd1) >= {1'b0, size_eff});
    end

    always_comb begin
        addlike = (type_reg == mfmd_pkg::TYPE_ADD) || (type_reg == mfmd_pkg::TYPE_ADD_MPID)
               || (type_reg == mfmd_pkg::TYPE_TRADE);
        exec    = (type_reg == mfmd_pkg::TYPE_EXEC) || (type_reg == mfmd_pkg::TYPE_EXEC_PX);
        hasref  = addlike || exec || (type_reg == mfmd_pkg::TYPE_CANCEL)
               || (type_reg == mfmd_pkg::TYPE_DELETE) || (type_reg == mfmd_pkg::TYPE_REPLACE);

        pos_next    = pos_reg;
        size_next   = size_reg;
        type_next   = type_reg;
        ref1_next   = ref1_reg;
        ref2_next   = ref2_reg;
        shares_next = shares_reg;
        price_next  = price_reg;
        mpid_next   = mpid_reg;
        side_next   = side_reg;
        locate_next = locate_reg;

        if (beat) begin
            if (pos_reg == 16'd0) begin
                size_next = {data, 8'h00};
            end else if (pos_reg == 16'd1) begin
                size_next = size_eff;
            end else if (pos_reg == 16'd2) begin
                // new message: clear the field registers
                type_next   = data;
                ref1_next   = '0;
                ref2_next   = '0;
                shares_next = '0;
                price_next  = '0;
                mpid_next   = '0;
                side_next   = '0;
                locate_next = '0;
            end else begin
                if (hasref && mfmd_pkg::in_span(pos_reg, 16'd3, 16'd10)) begin
                    ref1_next = {ref1_reg[55:0], data};
                end
                if (((type_reg == mfmd_pkg::TYPE_REPLACE)
                        && mfmd_pkg::in_span(pos_reg, 16'd11, 16'd18))
                    || (exec && mfmd_pkg::in_span(pos_reg, 16'd15, 16'd22))
                    || ((type_reg == mfmd_pkg::TYPE_TRADE)
                        && mfmd_pkg::in_span(pos_reg, 16'd21, 16'd28))) begin
                    ref2_next = {ref2_reg[55:0], data};
                end
                if ((addlike && mfmd_pkg::in_span(pos_reg, 16'd12, 16'd15))
                    || ((exec || (type_reg == mfmd_pkg::TYPE_CANCEL))
                        && mfmd_pkg::in_span(pos_reg, 16'd11, 16'd14))
                    || ((type_reg == mfmd_pkg::TYPE_REPLACE)
                        && mfmd_pkg::in_span(pos_reg, 16'd19, 16'd22))) begin
                    shares_next = {shares_reg[23:0], data};
                end
                if ((addlike && mfmd_pkg::in_span(pos_reg, 16'd17, 16'd20))
                    || ((type_reg == mfmd_pkg::TYPE_REPLACE)
                        && mfmd_pkg::in_span(pos_reg, 16'd23, 16'd26))) begin
                    price_next = {price_reg[23:0], data};
                end
                if (addlike && (pos_reg == 16'd11)) begin
                    side_next = data;
                end
                if ((addlike && (pos_reg == 16'd16))
                    || ((type_reg == mfmd_pkg::TYPE_DIR) && (pos_reg == 16'd3))) begin
                    locate_next = data;
                end
                if ((type_reg == mfmd_pkg::TYPE_ADD_MPID)
                    && mfmd_pkg::in_span(pos_reg, 16'd21, 16'd24)) begin
                    mpid_next = {mpid_reg[23:0], data};
                end
            end
            pos_next = last ? 16'd0 : pos_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg   <= size_next;
        type_reg   <= type_next;
        ref1_reg   <= ref1_next;
        ref2_reg   <= ref2_next;
        shares_reg <= shares_next;
        price_reg  <= price_next;
        mpid_reg   <= mpid_next;
        side_reg   <= side_next;
        locate_reg <= locate_next;
        // price lands many bytes before the last byte, so scaling is registered
        scaled_reg <= 39'(price_reg) * mfmd_pkg::PRICE_SCALE;
    end

    always_comb begin
        cap.emit         = beat && last;
        cap.msg_size     = size_eff;
        cap.msg_type     = type_eff;
        cap.first_ref    = ref1_reg;
        cap.second_ref   = ref2_reg;
        cap.shares       = shares_reg;
        cap.scaled_price = scaled_reg;
        cap.mpid         = mpid_reg;
        cap.side         = side_reg;
        cap.locate       = locate_reg;
    end

endmodule

`default_nettype wire

[rtl/mfmd_symbol_map.sv]
// ----------------------------------------------------------------------------
// mfmd_symbol_map
// Maps locate codes to dense symbol ids, assigned in order of first sight.
// ----------------------------------------------------------------------------
`default_nettype none

module mfmd_symbol_map #(
    parameter int LOCATE_ENTRIES = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] locate,
    input  wire logic       lookup,
    output logic [8:0]      symbol
);

    localparam int          IDX_W     = $clog2(LOCATE_ENTRIES);
    localparam int          RECIP     = (65536 + LOCATE_ENTRIES - 1) / LOCATE_ENTRIES;
    localparam logic [23:0] RECIP_W   = 24'(RECIP);
    localparam logic [15:0] ENTRIES_W = 16'(LOCATE_ENTRIES);

    logic [8:0]                sym_mem [LOCATE_ENTRIES];
    logic [LOCATE_ENTRIES-1:0] valid_reg;
    logic [8:0]                next_sym_reg;
    logic [8:0]                rd_data_reg;
    logic [7:0]                quot_reg;
    logic [IDX_W-1:0]          idx_reg;

    logic [23:0] quot_prod;
    logic [15:0] rem_full;
    logic        hit;

    // locate mod entries by reciprocal multiply; exact for 8-bit locates
    always_comb begin
        quot_prod = 24'(locate) * RECIP_W;
        rem_full  = 16'(locate) - (16'(quot_reg) * ENTRIES_W);
        hit       = valid_reg[idx_reg];
        symbol    = hit ? rd_data_reg : next_sym_reg;
    end

    always_ff @(posedge aclk) begin
        quot_reg    <= quot_prod[23:16];
        idx_reg     <= rem_full[IDX_W-1:0];
        rd_data_reg <= sym_mem[idx_reg];
        if (lookup && !hit) begin
            sym_mem[idx_reg] <= next_sym_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            next_sym_reg <= 9'd1;
        end else if (lookup && !hit) begin
            valid_reg[idx_reg] <= 1'b1;
            next_sym_reg       <= next_sym_reg + 9'd1;
        end
    end

endmodule

`default_nettype wire

[rtl/mfmd_out_skid.sv]
// ----------------------------------------------------------------------------
// mfmd_out_skid
// Output register with a skid stage so input ready is a registered signal.
// ----------------------------------------------------------------------------
`default_nettype none

module mfmd_out_skid (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    input  wire mfmd_pkg::res_t in_data,
    output logic                in_ready,
    output logic                out_valid,
    output mfmd_pkg::res_t      out_data,
    input  wire logic           out_ready
);

    logic           out_valid_reg;
    logic           skid_valid_reg;
    mfmd_pkg::res_t out_data_reg;
    mfmd_pkg::res_t skid_data_reg;
    logic           out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && in_ready) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

[rtl/market_feed_message_decoder_core.sv]
// ----------------------------------------------------------------------------
// market_feed_message_decoder_core
// Byte-serial decoder for a length-prefixed market feed, one event per message.
// ----------------------------------------------------------------------------
// output: an event beat is registered in the output stage when the last byte
//   of its message is accepted, or held in the skid stage while m_axis stalls
// throughput: one byte per cycle (single capture pass) unless the skid is full
// reset: aresetn low clears byte position, symbol valid bits, next symbol id
//   and both output stages; no table clearing pass is needed
`default_nettype none

module market_feed_message_decoder_core #(
    parameter int LOCATE_ENTRIES = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream, one byte per beat
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // stream_byte
    // decoded events
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // order_ref[63:0], new_order_ref[127:64], share_count[159:128],
    // scaled_price[198:160], is_sell[199], symbol_number[208:200],
    // match_ref[272:209], mpid_word[304:273], mpid_present[305], zero pad
    output logic [311:0]      m_axis_tdata,
    output logic [3:0]        m_axis_tuser    // event_kind
);

    logic           in_beat;
    logic           in_ready;
    mfmd_pkg::cap_t cap;
    mfmd_pkg::res_t res;
    mfmd_pkg::res_t out_res;
    logic [8:0]     symbol;
    logic           sym_lookup;
    logic           is_sell;

    assign in_beat       = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;

    // position tracking and field shift registers
    mfmd_field_capture u_capture (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat    (in_beat),
        .data    (s_axis_tdata),
        .cap     (cap)
    );

    // locate to dense symbol id; table read is pipelined off the stored
    // locate byte, which is captured long before the message ends
    mfmd_symbol_map #(
        .LOCATE_ENTRIES (LOCATE_ENTRIES)
    ) u_symbol_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .locate  (cap.locate),
        .lookup  (sym_lookup),
        .symbol  (symbol)
    );

    // event build: kind from type and length, unused fields forced to zero
    always_comb begin
        res     = '0;
        is_sell = (cap.side != mfmd_pkg::SIDE_BUY);

        if (cap.msg_size < mfmd_pkg::MIN_LEN_TYPED) begin
            // no type byte at all
            res.event_kind = mfmd_pkg::KIND_ERROR;
        end else begin
            unique case (cap.msg_type) inside
                mfmd_pkg::TYPE_ADD, mfmd_pkg::TYPE_ADD_MPID: begin
                    if (cap.msg_size < mfmd_pkg::MIN_LEN_ADD) begin
                        res.event_kind = mfmd_pkg::KIND_ERROR;
                    end else begin
                        res.event_kind    = mfmd_pkg::KIND_ADD;
                        res.order_ref     = cap.first_ref;
                        res.share_count   = cap.shares;
                        res.scaled_price  = cap.scaled_price;
                        res.is_sell       = is_sell;
                        res.symbol_number = symbol;
                        if (cap.msg_type == mfmd_pkg::TYPE_ADD_MPID) begin
                            res.mpid_word    = cap.mpid;
                            res.mpid_present = 1'b1;
                        end
                    end
                end
                mfmd_pkg::TYPE_EXEC, mfmd_pkg::TYPE_EXEC_PX: begin
                    if (cap.msg_size < mfmd_pkg::MIN_LEN_EXEC) begin
                        res.event_kind = mfmd_pkg::KIND_ERROR;
                    end else begin
                        res.event_kind  = mfmd_pkg::KIND_EXEC;
                        res.order_ref   = cap.first_ref;
                        res.share_count = cap.shares;
                        res.match_ref   = cap.second_ref;
                    end
                end
                mfmd_pkg::TYPE_CANCEL: begin
                    if (cap.msg_size < mfmd_pkg::MIN_LEN_CANCEL) begin
                        res.event_kind = mfmd_pkg::KIND_ERROR;
                    end else begin
                        res.event_kind  = mfmd_pkg::KIND_CANCEL;
                        res.order_ref   = cap.first_ref;
                        res.share_count = cap.shares;
                    end
                end
                mfmd_pkg::TYPE_DELETE: begin
                    if (cap.msg_size < mfmd_pkg::MIN_LEN_DELETE) begin
                        res.event_kind = mfmd_pkg::KIND_ERROR;
                    end else begin
                        res.event_kind = mfmd_pkg::KIND_DELETE;
                        res.order_ref  = cap.first_ref;
                    end
                end
                mfmd_pkg::TYPE_REPLACE: begin
                    if (cap.msg_size < mfmd_pkg::MIN_LEN_REPLACE) begin
                        res.event_kind = mfmd_pkg::KIND_ERROR;
                    end else begin
                        res.event_kind    = mfmd_pkg::KIND_REPLACE;
                        res.order_ref     = cap.first_ref;
                        res.new_order_ref = cap.second_ref;
                        res.share_count   = cap.shares;
                        res.scaled_price  = cap.scaled_price;
                    end
                end
                mfmd_pkg::TYPE_TRADE: begin
                    if (cap.msg_size < mfmd_pkg::MIN_LEN_TRADE) begin
                        res.event_kind = mfmd_pkg::KIND_ERROR;
                    end else begin
                        res.event_kind    = mfmd_pkg::KIND_TRADE;
                        res.order_ref     = cap.first_ref;
                        res.share_count   = cap.shares;
                        res.scaled_price  = cap.scaled_price;
                        res.is_sell       = is_sell;
                        res.symbol_number = symbol;
                        res.match_ref     = cap.second_ref;
                    end
                end
                mfmd_pkg::TYPE_DIR: begin
                    if (cap.msg_size < mfmd_pkg::MIN_LEN_DIR) begin
                        res.event_kind = mfmd_pkg::KIND_ERROR;
                    end else begin
                        res.event_kind    = mfmd_pkg::KIND_DIR;
                        res.symbol_number = symbol;
                    end
                end
                default: begin
                    res.event_kind = mfmd_pkg::KIND_IGNORED;
                end
            endcase
        end

        // only a valid add, trade or directory event assigns an id
        sym_lookup = cap.emit && ((res.event_kind == mfmd_pkg::KIND_ADD)
                                  || (res.event_kind == mfmd_pkg::KIND_TRADE)
                                  || (res.event_kind == mfmd_pkg::KIND_DIR));
    end

    // result register plus skid stage
    mfmd_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cap.emit),
        .in_data   (res),
        .in_ready  (in_ready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tuser = out_res.event_kind;
    assign m_axis_tdata = {6'b0,
                           out_res.mpid_present,
                           out_res.mpid_word,
                           out_res.match_ref,
                           out_res.symbol_number,
                           out_res.is_sell,
                           out_res.scaled_price,
                           out_res.share_count,
                           out_res.new_order_ref,
                           out_res.order_ref};

endmodule

`default_nettype wire
